// ----- src/srsd_pkg.sv -----
// shared types and constants for the segmented rc4 stream decryptor
// no dependencies; used by srsd_div and segmented_rc4_stream_decrypt_top
`default_nettype none

package srsd_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    OP_LOAD_KEY = 2'd0,
    OP_START    = 2'd1,
    OP_DECRYPT  = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  // stream segmentation
  localparam int FIRST_SEG_BYTES = 128;
  localparam int SEG_BYTES       = 5120;
  localparam int SEED_MASK_W     = 9;    // seed index uses seg & 0x1ff, discard count uses the segment key & 0x1ff
  localparam int HASH_SCALE      = 100;

  // shared divider widths
  localparam int DIV_NUM_W = 40;  // hash * 100 fits in 39 bits
  localparam int DIV_DEN_W = 41;  // (segment + 1) * seed fits in 41 bits
  localparam int DIV_CNT_W = 6;
  localparam int HASH_DIV_ITERS = 39;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- src/srsd_div.sv -----
// shared restoring divider, one quotient bit per cycle
// depends on srsd_pkg for widths and the request/response structs
`default_nettype none

module srsd_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire srsd_pkg::div_req_t             req,
  input  wire logic [srsd_pkg::DIV_NUM_W-1:0] dividend,
  input  wire logic [srsd_pkg::DIV_DEN_W-1:0] divisor,
  output srsd_pkg::div_rsp_t                  rsp,
  output logic [srsd_pkg::DIV_NUM_W-1:0]      quotient,
  output logic [srsd_pkg::DIV_DEN_W-1:0]      remainder
);
  import srsd_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_NUM_W-1:0] dvd_r;
  logic [DIV_DEN_W-1:0] dsr_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_CNT_W-1:0] bit_idx;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  // only the low iters bits of the dividend are consumed, msb first
  always_comb begin
    bit_idx = cnt_r - DIV_CNT_W'(1);
    trial   = {rem_r, dvd_r[bit_idx]};
    diff    = trial - {1'b0, dsr_r};
    ge      = (trial >= {1'b0, dsr_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.iters;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      quo_r <= '0;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_NUM_W-2:0], ge};
      rem_r <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
    end
  end

  assign rsp.busy  = busy_r;
  assign rsp.done  = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// ----- src/segmented_rc4_stream_decrypt_top.sv -----
// segmented rc4 stream decryptor: sequencer, key store and permutation memories
// depends on srsd_pkg and srsd_div (shared divider for every modulo and quotient)
//
// usage
//   cfg channel writes key_length (N, the modulus of computed key and permutation
//   indices); N = 0 acts as 1 and N above MAX_KEY_LEN saturates. cfg_ready is
//   always high; write only while the block is idle.
//   input items: operation 0 stores key_byte at key_index, operation 1 hashes
//   the key and rewinds the stream, operation 2 decrypts data_byte and yields
//   one output item, operation 3 is ignored.
// flow control and work per item
//   in_ready is high only while the sequencer is idle; one item is worked on
//   at a time. a steady decrypt byte needs three modulo-N reductions through
//   the shared one-bit-per-cycle divider. first-segment bytes need an 8-step
//   division and two 39-step divisions, the first skipped for a zero seed.
//   a re-key (every 5120 bytes and after byte 127) refills the N permutation
//   entries, runs the key schedule over N key bytes, reads the seed byte and
//   discards up to 639 rc4 outputs.
// reset and stalls
//   rst_n clears control state, hash to 1 and key_length to 512; the memories
//   are not cleared. a finished byte sits in the output register; the next
//   item is still accepted, and a later result waits until the slot frees.
`default_nettype none

module segmented_rc4_stream_decrypt_top #(
  parameter int MAX_KEY_LEN = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_key_length,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [9:0]  in_key_index,
  input  wire logic [7:0]  in_key_byte,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_plain_byte
);
  import srsd_pkg::*;

  localparam int AW   = $clog2(MAX_KEY_LEN);      // store address bits
  localparam int NW   = $clog2(MAX_KEY_LEN + 1);  // holds N itself
  localparam int CW   = (NW > 11) ? NW : 11;
  localparam int KW   = ((AW > 10) ? AW : 10) + 1;
  localparam int SUMW = AW + 1;                   // width of index sums before reduction

  typedef enum logic [5:0] {
    S_IDLE, S_DIV_WAIT,
    S_H_RD, S_H_MUL, S_H_CHK,
    S_D_START, S_F_SEED, S_F_SEEDQ, S_F_KS, S_F_KSRD, S_F_KSQ,
    S_SK_MUL, S_SK_DIV, S_SK_END,
    S_RK_INIT, S_RK_FILL, S_RK_KRD, S_RK_KSUM, S_RK_JRD, S_RK_SW1, S_RK_SW2,
    S_RK_SEED, S_RK_SEEDRD, S_RK_SEEDQ, S_RK_DISC0, S_RK_DISC,
    S_R_NEXT, S_R_ARD, S_R_ASUM, S_R_BRD, S_R_SW1, S_R_SW2, S_R_ORD,
    S_L_STEP, S_L_DONE, S_EMIT
  } state_t;

  // ---------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------
  state_t          state_r, ret_r, sk_ret_r, rk_ret_r, rc_ret_r;
  logic [10:0]     key_length_r;
  logic [31:0]     hash_r, h_r, prod_r;
  logic [AW-1:0]   i_r, j_r, kj_r;
  logic [NW-1:0]   k_r;
  logic [12:0]     sbl_r;
  logic [31:0]     seg_r;
  logic [7:0]      fsp_r;
  logic [7:0]      data_r, ks_r, seed_r, sa_r, sb_r;
  logic [31:0]     sk_s_r;
  logic [DIV_NUM_W-1:0] sk_r, num_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [9:0]      disc_r;
  logic            extra_r;
  logic            out_valid_r;
  logic [7:0]      out_plain_r;

  div_req_t             div_req_r;
  logic [DIV_NUM_W-1:0] div_dvd_r;
  logic [DIV_DEN_W-1:0] div_dsr_r;
  div_rsp_t             div_rsp;
  logic [DIV_NUM_W-1:0] div_quo;
  logic [DIV_DEN_W-1:0] div_rem;

  // memories
  logic [7:0] key_mem [MAX_KEY_LEN];
  logic [7:0] perm_mem [MAX_KEY_LEN];
  logic [7:0] key_q, perm_q;

  // ---------------------------------------------------------------------
  // effective key length and small helpers
  // ---------------------------------------------------------------------
  logic [CW-1:0] kl_ext;
  logic [NW-1:0] n_w;
  logic [KW-1:0] kidx_ext;
  logic [AW-1:0] kidx;
  logic [AW-1:0] rem_a;
  logic          in_acc;
  op_t           op_in;

  always_comb begin
    kl_ext = CW'(key_length_r);
    if (key_length_r == 11'd0) begin
      n_w = NW'(1);
    end else if (kl_ext > CW'(MAX_KEY_LEN)) begin
      n_w = NW'(MAX_KEY_LEN);
    end else begin
      n_w = kl_ext[NW-1:0];
    end
    // key_index is below 2 * MAX_KEY_LEN, one subtract wraps it
    kidx_ext = KW'(in_key_index);
    if (kidx_ext >= KW'(MAX_KEY_LEN)) begin
      kidx_ext = kidx_ext - KW'(MAX_KEY_LEN);
    end
    kidx = kidx_ext[AW-1:0];
  end

  assign rem_a  = div_rem[AW-1:0];
  assign op_in  = op_t'(in_operation);
  assign in_acc = in_valid && in_ready;

  assign cfg_ready      = 1'b1;
  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_plain_byte = out_plain_r;

  // ---------------------------------------------------------------------
  // memory ports
  // ---------------------------------------------------------------------
  logic          key_we, key_re, perm_we, perm_re;
  logic [AW-1:0] key_ra, perm_ra, perm_wa;
  logic [7:0]    perm_wd;

  always_comb begin
    key_we  = in_acc && (op_in == OP_LOAD_KEY);
    key_re  = 1'b0;
    key_ra  = rem_a;
    perm_re = 1'b0;
    perm_ra = rem_a;
    perm_we = 1'b0;
    perm_wa = k_r[AW-1:0];
    perm_wd = k_r[7:0];
    unique case (state_r)
      S_H_RD:      begin key_re = (k_r < n_w); key_ra = k_r[AW-1:0]; end
      S_F_SEED:    key_re = 1'b1;
      S_F_KSRD:    key_re = 1'b1;
      S_RK_SEEDRD: key_re = 1'b1;
      S_RK_FILL:   perm_we = (k_r < n_w);
      S_RK_KRD: begin
        key_re  = 1'b1;
        key_ra  = k_r[AW-1:0];
        perm_re = 1'b1;
        perm_ra = k_r[AW-1:0];
      end
      S_RK_JRD:    perm_re = 1'b1;
      S_RK_SW1: begin
        perm_we = 1'b1;
        perm_wd = perm_q;
      end
      S_RK_SW2: begin
        perm_we = 1'b1;
        perm_wa = kj_r;
        perm_wd = sa_r;
      end
      S_R_ARD:     perm_re = 1'b1;
      S_R_BRD:     perm_re = 1'b1;
      S_R_SW1: begin
        perm_we = 1'b1;
        perm_wa = i_r;
        perm_wd = perm_q;
      end
      S_R_SW2: begin
        perm_we = 1'b1;
        perm_wa = j_r;
        perm_wd = sa_r;
      end
      S_R_ORD:     perm_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[kidx] <= in_key_byte;
    if (key_re) key_q <= key_mem[key_ra];
  end

  always_ff @(posedge clk) begin
    if (perm_we) perm_mem[perm_wa] <= perm_wd;
    if (perm_re) perm_q <= perm_mem[perm_ra];
  end

  // ---------------------------------------------------------------------
  // shared divider
  // ---------------------------------------------------------------------
  srsd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (div_req_r),
    .dividend  (div_dvd_r),
    .divisor   (div_dsr_r),
    .rsp       (div_rsp),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // states that launch a division
  logic div_go;

  always_comb begin
    div_go = 1'b0;
    unique case (state_r) inside
      S_D_START: div_go = (fsp_r < 8'(FIRST_SEG_BYTES));
      S_F_KS, S_SK_DIV, S_RK_KSUM, S_RK_SEED, S_R_NEXT, S_R_ASUM, S_R_SW2: begin
        div_go = 1'b1;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      ret_r           <= S_IDLE;
      sk_ret_r        <= S_IDLE;
      rk_ret_r        <= S_IDLE;
      rc_ret_r        <= S_IDLE;
      key_length_r    <= 11'd512;
      hash_r          <= 32'd1;
      i_r             <= '0;
      j_r             <= '0;
      sbl_r           <= '0;
      seg_r           <= '0;
      fsp_r           <= '0;
      out_valid_r     <= 1'b0;
      div_req_r.start <= 1'b0;
      div_req_r.iters <= '0;
    end else begin
      div_req_r.start <= div_go;
      if (cfg_valid && cfg_ready) key_length_r <= cfg_key_length;
      // the emit state refills the slot itself
      if (out_valid_r && out_ready && state_r != S_EMIT) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            data_r <= in_data_byte;
            unique case (op_in)
              OP_START: begin
                h_r     <= 32'd1;
                k_r     <= '0;
                fsp_r   <= '0;
                seg_r   <= '0;
                sbl_r   <= '0;
                i_r     <= '0;
                j_r     <= '0;
                state_r <= S_H_RD;
              end
              OP_DECRYPT: state_r <= S_D_START;
              default: ;
            endcase
          end
        end

        S_DIV_WAIT: if (div_rsp.done) state_r <= ret_r;

        // key hash: product over nonzero bytes while it keeps growing
        S_H_RD: begin
          if (k_r < n_w) begin
            state_r <= S_H_MUL;
          end else begin
            hash_r  <= h_r;
            state_r <= S_IDLE;
          end
        end
        S_H_MUL: begin
          if (key_q == 8'd0) begin
            k_r     <= k_r + NW'(1);
            state_r <= S_H_RD;
          end else begin
            prod_r  <= h_r * 32'(key_q);
            state_r <= S_H_CHK;
          end
        end
        S_H_CHK: begin
          if (prod_r == 32'd0 || prod_r <= h_r) begin
            hash_r  <= h_r;
            state_r <= S_IDLE;
          end else begin
            h_r     <= prod_r;
            k_r     <= k_r + NW'(1);
            state_r <= S_H_RD;
          end
        end

        // decrypt dispatch
        S_D_START: begin
          if (fsp_r < 8'(FIRST_SEG_BYTES)) begin
            div_req_r.iters <= DIV_CNT_W'(8);
            div_dvd_r       <= DIV_NUM_W'(fsp_r);
            div_dsr_r       <= DIV_DEN_W'(n_w);
            ret_r           <= S_F_SEED;
            state_r         <= S_DIV_WAIT;
          end else if (sbl_r == 13'd0) begin
            extra_r  <= 1'b0;
            rk_ret_r <= S_L_STEP;
            state_r  <= S_RK_INIT;
          end else begin
            state_r <= S_L_STEP;
          end
        end

        // first segment: key byte picked by the hash quotient
        S_F_SEED:  state_r <= S_F_SEEDQ;
        S_F_SEEDQ: begin
          seed_r   <= key_q;
          sk_s_r   <= 32'(fsp_r);
          sk_ret_r <= S_F_KS;
          state_r  <= S_SK_MUL;
        end
        S_F_KS: begin
          div_req_r.iters <= DIV_CNT_W'(HASH_DIV_ITERS);
          div_dvd_r       <= sk_r;
          div_dsr_r       <= DIV_DEN_W'(n_w);
          ret_r           <= S_F_KSRD;
          state_r         <= S_DIV_WAIT;
        end
        S_F_KSRD: state_r <= S_F_KSQ;
        S_F_KSQ: begin
          ks_r  <= key_q;
          fsp_r <= fsp_r + 8'd1;
          if (fsp_r == 8'(FIRST_SEG_BYTES - 1) && sbl_r == 13'd0) begin
            extra_r  <= 1'b1;
            rk_ret_r <= S_EMIT;
            state_r  <= S_RK_INIT;
          end else begin
            state_r <= S_EMIT;
          end
        end

        // segment key: hash * 100 / ((s + 1) * seed), zero for a zero seed
        S_SK_MUL: begin
          if (seed_r == 8'd0) begin
            sk_r    <= '0;
            state_r <= sk_ret_r;
          end else begin
            den_r   <= DIV_DEN_W'(({1'b0, sk_s_r} + 33'd1) * 41'(seed_r));
            num_r   <= DIV_NUM_W'(hash_r) * DIV_NUM_W'(HASH_SCALE);
            state_r <= S_SK_DIV;
          end
        end
        S_SK_DIV: begin
          div_req_r.iters <= DIV_CNT_W'(HASH_DIV_ITERS);
          div_dvd_r       <= num_r;
          div_dsr_r       <= den_r;
          ret_r           <= S_SK_END;
          state_r         <= S_DIV_WAIT;
        end
        S_SK_END: begin
          sk_r    <= div_quo;
          state_r <= sk_ret_r;
        end

        // re-key: identity fill, key schedule, seed, discards
        S_RK_INIT: begin
          i_r     <= '0;
          j_r     <= '0;
          k_r     <= '0;
          state_r <= S_RK_FILL;
        end
        S_RK_FILL: begin
          if (k_r < n_w) begin
            k_r <= k_r + NW'(1);
          end else begin
            k_r     <= '0;
            kj_r    <= '0;
            state_r <= S_RK_KRD;
          end
        end
        S_RK_KRD: state_r <= (k_r < n_w) ? S_RK_KSUM : S_RK_SEED;
        S_RK_KSUM: begin
          sa_r            <= perm_q;
          div_req_r.iters <= DIV_CNT_W'(SUMW);
          div_dvd_r       <= DIV_NUM_W'(perm_q) + DIV_NUM_W'(kj_r) + DIV_NUM_W'(key_q);
          div_dsr_r       <= DIV_DEN_W'(n_w);
          ret_r           <= S_RK_JRD;
          state_r         <= S_DIV_WAIT;
        end
        S_RK_JRD: begin
          kj_r    <= rem_a;
          state_r <= S_RK_SW1;
        end
        S_RK_SW1: state_r <= S_RK_SW2;
        S_RK_SW2: begin
          k_r     <= k_r + NW'(1);
          state_r <= S_RK_KRD;
        end
        S_RK_SEED: begin
          div_req_r.iters <= DIV_CNT_W'(SEED_MASK_W);
          div_dvd_r       <= DIV_NUM_W'(seg_r[SEED_MASK_W-1:0]);
          div_dsr_r       <= DIV_DEN_W'(n_w);
          ret_r           <= S_RK_SEEDRD;
          state_r         <= S_DIV_WAIT;
        end
        S_RK_SEEDRD: state_r <= S_RK_SEEDQ;
        S_RK_SEEDQ: begin
          seed_r   <= key_q;
          sk_s_r   <= seg_r;
          sk_ret_r <= S_RK_DISC0;
          state_r  <= S_SK_MUL;
        end
        S_RK_DISC0: begin
          disc_r  <= (extra_r ? 10'(FIRST_SEG_BYTES) : 10'd0)
                     + 10'(sk_r[SEED_MASK_W-1:0]);
          sbl_r   <= extra_r ? 13'(SEG_BYTES - FIRST_SEG_BYTES) : 13'(SEG_BYTES);
          state_r <= S_RK_DISC;
        end
        S_RK_DISC: begin
          if (disc_r == 10'd0) begin
            seg_r   <= seg_r + 32'd1;
            state_r <= rk_ret_r;
          end else begin
            disc_r   <= disc_r - 10'd1;
            rc_ret_r <= S_RK_DISC;
            state_r  <= S_R_NEXT;
          end
        end

        // one rc4 output step
        S_R_NEXT: begin
          div_req_r.iters <= DIV_CNT_W'(SUMW);
          div_dvd_r       <= DIV_NUM_W'(i_r) + DIV_NUM_W'(1);
          div_dsr_r       <= DIV_DEN_W'(n_w);
          ret_r           <= S_R_ARD;
          state_r         <= S_DIV_WAIT;
        end
        S_R_ARD: begin
          i_r     <= rem_a;
          state_r <= S_R_ASUM;
        end
        S_R_ASUM: begin
          sa_r            <= perm_q;
          div_req_r.iters <= DIV_CNT_W'(SUMW);
          div_dvd_r       <= DIV_NUM_W'(perm_q) + DIV_NUM_W'(j_r);
          div_dsr_r       <= DIV_DEN_W'(n_w);
          ret_r           <= S_R_BRD;
          state_r         <= S_DIV_WAIT;
        end
        S_R_BRD: begin
          j_r     <= rem_a;
          state_r <= S_R_SW1;
        end
        S_R_SW1: begin
          sb_r    <= perm_q;
          state_r <= S_R_SW2;
        end
        S_R_SW2: begin
          div_req_r.iters <= DIV_CNT_W'(SUMW);
          div_dvd_r       <= DIV_NUM_W'(sa_r) + DIV_NUM_W'(sb_r);
          div_dsr_r       <= DIV_DEN_W'(n_w);
          ret_r           <= S_R_ORD;
          state_r         <= S_DIV_WAIT;
        end
        S_R_ORD: state_r <= rc_ret_r;

        // later bytes
        S_L_STEP: begin
          rc_ret_r <= S_L_DONE;
          state_r  <= S_R_NEXT;
        end
        S_L_DONE: begin
          ks_r    <= perm_q;
          sbl_r   <= sbl_r - 13'd1;
          state_r <= S_EMIT;
        end

        // hand the byte to the output register once it is free
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_plain_r <= data_r ^ ks_r;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_div_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    (div_rsp.busy || div_rsp.done) |-> state_r == S_DIV_WAIT)
    else $error("divider active outside of a wait");

  a_decrypt_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && op_in == OP_DECRYPT) |=> state_r == S_D_START)
    else $error("decrypt item not dispatched");

  a_seg_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sbl_r <= 13'(SEG_BYTES) && fsp_r <= 8'(FIRST_SEG_BYTES))
    else $error("segment counters out of range");

  a_emit_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && (!out_valid_r || out_ready)) |=> out_valid_r && state_r == S_IDLE)
    else $error("result not registered on emit");

endmodule

`default_nettype wire

// ----- bench/tb_segmented_rc4_stream_decrypt_top.sv -----
// testbench for segmented_rc4_stream_decrypt_top: key loads, stream starts and
// decrypts checked against an in-bench predictor; depends on srsd_pkg and the rtl
`default_nettype none

module tb_segmented_rc4_stream_decrypt_top;
  import srsd_pkg::*;

  localparam int KEY_DEPTH = 1024;
  localparam int STALL_LIMIT = 200000;  // watchdog bound, above the longest re-key at full length
  localparam int LONG_HOLD = 3000;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [10:0] cfg_key_length;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_operation;
  logic [9:0]  in_key_index;
  logic [7:0]  in_key_byte;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_plain_byte;

  segmented_rc4_stream_decrypt_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_key_length(cfg_key_length),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_key_index  (in_key_index),
    .in_key_byte   (in_key_byte),
    .in_data_byte  (in_data_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_plain_byte(out_plain_byte)
  );

  // predictor state, a private copy of the block's state
  bit [7:0]    key_mem [KEY_DEPTH];
  bit [7:0]    perm_mem[KEY_DEPTH];
  bit [31:0]   hash_r;
  bit [31:0]   seg_num;
  int unsigned idx_i, idx_j, seg_left, first_pos;
  bit [10:0]   key_len_r;

  bit [7:0] plain_expected[$];  // plaintext bytes still to come out
  int       fail_count;
  bit       quiet;      // no idling on either side
  bit       long_hold;  // request a long receiver hold-off

  // ---------------------------------------------------------------- predictor

  // effective key length: zero acts as one, oversize saturates
  function automatic int unsigned eff_n();
    if (key_len_r == 0) return 1;
    if (key_len_r > KEY_DEPTH) return KEY_DEPTH;
    return 32'(key_len_r);
  endfunction

  // exact integer form of hash*100 / ((s+1)*seed)
  function automatic longint unsigned seg_quot(longint unsigned s, longint unsigned seed);
    longint unsigned d;
    if (seed == 0) return 0;
    d = (s + 1) * seed;
    return (64'(hash_r) * 64'd100) / d;
  endfunction

  function automatic bit [7:0] rc4_out(int unsigned n);
    int unsigned a, b;
    bit [7:0] t;
    a = (idx_i + 1) % n;
    b = (perm_mem[a] + idx_j) % n;
    idx_i = a;
    idx_j = b;
    t = perm_mem[a];
    perm_mem[a] = perm_mem[b];
    perm_mem[b] = t;
    return perm_mem[(perm_mem[a] + perm_mem[b]) % n];
  endfunction

  function automatic void rekey_stream(int unsigned n, int unsigned extra);
    int unsigned j, discards;
    bit [7:0] t, seed;
    bit [7:0] unused;
    idx_i = 0;
    idx_j = 0;
    j = 0;
    for (int unsigned k = 0; k < n; k++) perm_mem[k] = k[7:0];
    for (int unsigned k = 0; k < n; k++) begin
      j = (perm_mem[k] + j + key_mem[k]) % n;
      t = perm_mem[k];
      perm_mem[k] = perm_mem[j];
      perm_mem[j] = t;
    end
    seed = key_mem[(seg_num & 32'h1FF) % n];
    discards = extra + int'(seg_quot(seg_num, seed) & 64'h1FF);
    seg_left = SEG_BYTES - extra;
    for (int unsigned k = 0; k < discards; k++) unused = rc4_out(n);
    seg_num = seg_num + 1;
  endfunction

  // product of nonzero key bytes, stopping on wrap to zero or no growth
  function automatic void hash_key(int unsigned n);
    bit [31:0] h, nx;
    h = 1;
    for (int unsigned k = 0; k < n; k++) begin
      if (key_mem[k] == 0) continue;
      nx = h * key_mem[k];
      if (nx == 0 || nx <= h) break;
      h = nx;
    end
    hash_r = h;
  endfunction

  // apply one accepted item, queue the plaintext byte if it makes one
  function automatic void predict_item(op_t op, bit [9:0] ki, bit [7:0] kb, bit [7:0] db);
    int unsigned n, p;
    bit [7:0] ks;
    n = eff_n();
    case (op)
      OP_LOAD_KEY: key_mem[ki] = kb;
      OP_START: begin
        hash_key(n);
        first_pos = 0;
        seg_num = 0;
        seg_left = 0;
        idx_i = 0;
        idx_j = 0;
      end
      OP_DECRYPT: begin
        if (first_pos < FIRST_SEG_BYTES) begin
          p = first_pos;
          ks = key_mem[seg_quot(p, key_mem[p % n]) % n];
          first_pos = p + 1;
          if (first_pos == FIRST_SEG_BYTES && seg_left == 0)
            rekey_stream(n, FIRST_SEG_BYTES);
        end else begin
          if (seg_left == 0) rekey_stream(n, 0);
          ks = rc4_out(n);
          seg_left = seg_left - 1;
        end
        plain_expected.push_back(db ^ ks);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- clock, reset

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- shared tasks

  // one input item; valid stays high across back-to-back items
  task automatic send_item(op_t op, bit [9:0] ki, bit [7:0] kb, bit [7:0] db);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_key_index <= ki;
    in_key_byte  <= kb;
    in_data_byte <= db;
    do @(posedge clk); while (!in_ready);
    predict_item(op, ki, kb, db);
  endtask

  task automatic send_decrypt(bit [7:0] db);
    send_item(OP_DECRYPT, 10'($urandom), 8'($urandom), db);
  endtask

  task automatic send_start();
    send_item(OP_START, 10'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // drop valid, let every result drain and the sequencer go idle
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (plain_expected.size() != 0) @(posedge clk);
    while (!in_ready) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_key_length(bit [10:0] len);
    drain_block();
    cfg_valid      <= 1'b1;
    cfg_key_length <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    key_len_r = len;
  endtask

  // ---------------------------------------------------------------- tests

  // every key entry is written so no read ever hits an unwritten entry
  task automatic test_load_full_key();
    send_item(OP_LOAD_KEY, 10'd0, 8'd0, 8'hFF);
    send_item(OP_LOAD_KEY, 10'd1023, 8'hFF, 8'h00);
    for (int k = 1; k < KEY_DEPTH - 1; k++) begin
      send_item(OP_LOAD_KEY, 10'(k), 8'($urandom), 8'($urandom));
    end
  endtask

  // default length, hash still at its reset value
  task automatic test_decrypt_before_start();
    send_decrypt(8'h00);
    send_decrypt(8'hFF);
    send_item(OP_NONE, 10'h3FF, 8'hFF, 8'hFF);  // ignored
    send_decrypt(8'hA5);
  endtask

  // oversize length saturates; crossing byte 127 re-keys the whole table
  task automatic test_full_length_rekey();
    write_key_length(11'h7FF);
    send_start();
    for (int k = 0; k < 132; k++) send_decrypt(8'($urandom));
  endtask

  // small key: first byte zero (skipped), then bytes that grow the product and one that stops it
  task automatic test_hash_stop();
    write_key_length(11'd300);
    send_item(OP_LOAD_KEY, 10'd0, 8'd0, 8'd0);
    send_item(OP_LOAD_KEY, 10'd1, 8'd255, 8'd0);
    send_item(OP_LOAD_KEY, 10'd2, 8'd255, 8'd0);
    send_item(OP_LOAD_KEY, 10'd3, 8'd255, 8'd0);
    send_item(OP_LOAD_KEY, 10'd4, 8'd255, 8'd0);
    send_item(OP_LOAD_KEY, 10'd5, 8'd1, 8'd0);
    send_start();
    for (int k = 0; k < 140; k++) send_decrypt(8'($urandom));
  endtask

  // length changes while the stream is past its first segment
  task automatic test_length_change_midstream();
    write_key_length(11'd1024);
    for (int k = 0; k < 20; k++) send_decrypt(8'($urandom));
    write_key_length(11'd700);
    for (int k = 0; k < 20; k++) send_decrypt(8'($urandom));
  endtask

  // zero length acts as one; runs well past the first segment
  task automatic test_segment_boundary();
    write_key_length(11'd0);
    send_start();
    for (int k = 0; k < FIRST_SEG_BYTES + 72; k++) send_decrypt(8'($urandom));
  endtask

  // receiver holds off while decrypts keep coming
  task automatic test_output_backpressure();
    write_key_length(11'd512);
    send_start();
    long_hold = 1'b1;
    for (int k = 0; k < 40; k++) send_decrypt(8'($urandom));
  endtask

  // mostly decrypts, with key rewrites, restarts, ignored items and new lengths
  task automatic test_random_mix();
    int unsigned pick;
    bit [10:0] lens[6];
    lens = '{11'd300, 11'd1024, 11'd2047, 11'd0, 11'd517, 11'd863};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) quiet = 1'b1;  // last stretch runs without idling
      write_key_length(ph == 5 ? 11'($urandom_range(300, 1024)) : lens[ph]);
      send_start();
      for (int k = 0; k < 70; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) send_decrypt(8'($urandom));
        else if (pick < 94) send_item(OP_LOAD_KEY, 10'($urandom), 8'($urandom), 8'($urandom));
        else if (pick < 98) send_item(OP_NONE, 10'($urandom), 8'($urandom), 8'($urandom));
        else send_start();
      end
    end
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        // long hold-off, counted here, so the output slot fills and input stalls
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- result check

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (plain_expected.size() == 0) begin
        $error("plain_byte: unexpected item, actual %0h", out_plain_byte);
        fail_count++;
      end else begin
        if (out_plain_byte !== plain_expected[0]) begin
          $error("plain_byte: expected %0h actual %0h", plain_expected[0], out_plain_byte);
          fail_count++;
        end
        void'(plain_expected.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  int unsigned stall_cycles;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("segmented_rc4_stream_decrypt_top regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n          <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_key_length <= '0;
    in_valid       <= 1'b0;
    in_operation   <= OP_NONE;
    in_key_index   <= '0;
    in_key_byte    <= '0;
    in_data_byte   <= '0;
    fail_count = 0;
    quiet      = 1'b0;
    long_hold  = 1'b0;
    hash_r     = 1;
    seg_num    = 0;
    idx_i      = 0;
    idx_j      = 0;
    seg_left   = 0;
    first_pos  = 0;
    key_len_r  = 11'd512;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_load_full_key();
    test_decrypt_before_start();
    test_full_length_rekey();
    test_hash_stop();
    test_length_change_midstream();
    test_segment_boundary();
    test_output_backpressure();
    test_random_mix();

    drain_block();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("segmented_rc4_stream_decrypt_top regression: pass");
    end else begin
      $display("segmented_rc4_stream_decrypt_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
